// File: rtl/plbc_pkg.sv
// Package with shared codes, state type and defaults for the pinned LRU byte-budget cache.
`timescale 1ns / 1ps
`default_nettype none

package plbc_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_ENTRIES   = 16;
    localparam int DEF_LOCK_BITS = 8;

    // Byte budget after reset: 40 MiB
    localparam logic [30:0] DEFAULT_LIMIT = 31'(40 * 1024 * 1024);

    // Operation codes
    localparam logic [3:0] OP_INSERT = 4'd0;
    localparam logic [3:0] OP_TOUCH  = 4'd1;
    localparam logic [3:0] OP_LOCK   = 4'd2;
    localparam logic [3:0] OP_UNLOCK = 4'd3;
    localparam logic [3:0] OP_REMOVE = 4'd4;
    localparam logic [3:0] OP_FLUSH  = 4'd5;
    localparam logic [3:0] OP_TRIM   = 4'd6;
    localparam logic [3:0] OP_DIRTY  = 4'd7;
    localparam logic [3:0] OP_CLEAN  = 4'd8;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ABSENT    = 3'd1;
    localparam logic [2:0] ST_PRESENT   = 3'd2;
    localparam logic [2:0] ST_UNDERFLOW = 3'd3;
    localparam logic [2:0] ST_NOFLUSH   = 3'd4;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_SCAN,
        S_DEC,
        S_EVOUT,
        S_WRNEW,
        S_INSFIN,
        S_FINAL
    } state_t;

endpackage

`default_nettype wire

// File: rtl/plbc_mem.sv
// Entry record memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module plbc_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 44
) (
    input  wire logic                     clk,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write the addressed entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/pinned_lru_byte_budget_cache_core.sv
// Top level: sequencer, present bits, byte total and result register of the cache controller.
//
//  channel | signals                                          | handshake
//  --------+--------------------------------------------------+-------------------
//  input   | op, entry, size_bytes                            | in_valid / in_ready
//  result  | evicted_valid, evicted_entry, evicted_dirty,     | out_valid / out_ready
//          | status, used_bytes, last                         |
//  config  | cfg_wdata (cache_limit)                          | cfg_we, no wait
//
// Touch, lock and remove add a rank sweep over all entries. Each eviction costs a victim
// scan and a rank sweep, set by the single read port of the entry memory. Reset clears
// the present bits, the count, the byte total and restores the 40 MiB limit; the memory
// needs no clearing. A stalled result word holds the sequencer at its next emit step.
`timescale 1ns / 1ps
`default_nettype none

module pinned_lru_byte_budget_cache_core #(
    parameter int ENTRIES   = plbc_pkg::DEF_ENTRIES,
    parameter int LOCK_BITS = plbc_pkg::DEF_LOCK_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [30:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [3:0]  op,
    input  wire logic [3:0]  entry,
    input  wire logic [30:0] size_bytes,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             evicted_valid,
    output logic [3:0]       evicted_entry,
    output logic             evicted_dirty,
    output logic [2:0]       status,
    output logic [34:0]      used_bytes,
    output logic             last
);

    import plbc_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef struct packed {
        logic [30:0]          size;
        logic [LOCK_BITS-1:0] locks;
        logic                 modified;
        logic [IW-1:0]        rank;
    } rec_t;

    localparam int RW = $bits(rec_t);

    state_t state_reg, state_next;

    logic [30:0]        limit_reg;
    logic [34:0]        used_reg;
    logic [ENTRIES-1:0] present_reg;
    logic [CW-1:0]      count_reg;

    logic [3:0]  op_reg;
    logic [3:0]  entry_reg;
    logic [30:0] size_reg;
    logic [2:0]  st_reg;
    logic        df_reg;
    logic        drop_reg;
    rec_t        rec_reg;

    logic [CW-1:0] ptr_reg;
    logic          pend_reg;
    logic [IW-1:0] paddr_reg;
    logic          best_v_reg;
    logic [IW-1:0] vic_idx_reg;
    logic [IW-1:0] vic_rank_reg;
    logic [30:0]   vic_size_reg;
    logic          vic_mod_reg;

    logic        out_valid_reg;
    logic        ev_valid_reg;
    logic [3:0]  ev_entry_reg;
    logic        ev_dirty_reg;
    logic [2:0]  status_reg;
    logic [34:0] used_out_reg;
    logic        last_reg;

    logic [IW-1:0] raddr;
    logic [RW-1:0] rdata_raw;
    rec_t          rdata;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    rec_t          mem_wdata;

    logic [IW-1:0] e_idx;
    logic          in_range;
    logic          e_present;
    logic          over;
    logic          sweep_done;
    logic          out_free;
    logic          emit_ev;
    logic          emit_fin;
    logic          scan_hit;

    plbc_mem #(
        .DEPTH (ENTRIES),
        .WIDTH (RW)
    ) u_mem (
        .clk   (clk),
        .raddr (raddr),
        .rdata (rdata_raw),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata)
    );

    assign rdata = rec_t'(rdata_raw);

    // Decode helpers
    assign e_idx      = IW'(entry_reg);
    assign in_range   = (32'(entry_reg) < ENTRIES);
    assign e_present  = in_range && present_reg[e_idx];
    assign over       = (used_reg > 35'(limit_reg));
    assign sweep_done = (ptr_reg == CW'(ENTRIES)) && !pend_reg;
    assign out_free   = !out_valid_reg || out_ready;
    assign scan_hit   = pend_reg && present_reg[paddr_reg] && (rdata.locks == '0) &&
                        (!best_v_reg || (rdata.rank < vic_rank_reg));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (op_reg > OP_CLEAN)
                begin
                    state_next = S_FINAL;
                end
                else if (op_reg == OP_FLUSH)
                begin
                    state_next = S_SCAN;
                end
                else if (op_reg == OP_TRIM)
                begin
                    state_next = S_CHECK;
                end
                else if (!in_range)
                begin
                    state_next = S_FINAL;
                end
                else if (op_reg == OP_INSERT)
                begin
                    state_next = e_present ? S_FINAL : S_CHECK;
                end
                else if (!e_present)
                begin
                    state_next = S_FINAL;
                end
                else if (op_reg == OP_TOUCH || op_reg == OP_LOCK || op_reg == OP_REMOVE)
                begin
                    state_next = S_DEC;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_CHECK:
            begin
                if (over)
                begin
                    state_next = S_SCAN;
                end
                else if (op_reg == OP_INSERT)
                begin
                    state_next = S_INSFIN;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_SCAN:
            begin
                if (sweep_done)
                begin
                    if (best_v_reg)
                    begin
                        state_next = S_DEC;
                    end
                    else if (op_reg == OP_INSERT)
                    begin
                        state_next = S_INSFIN;
                    end
                    else
                    begin
                        state_next = S_FINAL;
                    end
                end
            end
            S_DEC:
            begin
                if (sweep_done)
                begin
                    if (op_reg == OP_TOUCH || op_reg == OP_LOCK)
                    begin
                        state_next = S_WRNEW;
                    end
                    else if (op_reg == OP_REMOVE)
                    begin
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        state_next = S_EVOUT;
                    end
                end
            end
            S_EVOUT:
            begin
                if (out_free)
                begin
                    state_next = (op_reg == OP_FLUSH) ? S_FINAL : S_CHECK;
                end
            end
            S_WRNEW:  state_next = S_FINAL;
            S_INSFIN: state_next = S_FINAL;
            S_FINAL:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory port and result emits
    always_comb
    begin
        in_ready  = 1'b0;
        raddr     = ptr_reg[IW-1:0];
        mem_we    = 1'b0;
        mem_waddr = e_idx;
        mem_wdata = rdata;
        emit_ev   = 1'b0;
        emit_fin  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                raddr    = IW'(entry);
            end
            S_DECODE:
            begin
                if (e_present)
                begin
                    case (op_reg)
                        OP_UNLOCK:
                        begin
                            mem_we          = (rdata.locks != '0);
                            mem_wdata.locks = rdata.locks - 1'b1;
                        end
                        OP_DIRTY:
                        begin
                            mem_we             = 1'b1;
                            mem_wdata.modified = 1'b1;
                        end
                        OP_CLEAN:
                        begin
                            mem_we             = 1'b1;
                            mem_wdata.modified = 1'b0;
                        end
                        default: mem_we = 1'b0;
                    endcase
                end
            end
            S_DEC:
            begin
                mem_waddr      = paddr_reg;
                mem_wdata.rank = rdata.rank - 1'b1;
                mem_we         = pend_reg && present_reg[paddr_reg] &&
                                 (rdata.rank > vic_rank_reg);
            end
            S_WRNEW:
            begin
                mem_we         = 1'b1;
                mem_wdata      = rec_reg;
                mem_wdata.rank = IW'(count_reg - 1'b1);
            end
            S_INSFIN:
            begin
                mem_we             = 1'b1;
                mem_wdata.size     = size_reg;
                mem_wdata.locks    = '0;
                mem_wdata.modified = 1'b0;
                mem_wdata.rank     = IW'(count_reg);
            end
            S_EVOUT:  emit_ev  = out_free;
            S_FINAL:  emit_fin = out_free;
            default:  mem_we   = 1'b0;
        endcase
    end

    // Sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            limit_reg   <= DEFAULT_LIMIT;
            used_reg    <= '0;
            present_reg <= '0;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            ptr_reg     <= '0;
            best_v_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Take a new limit
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end

            // Add the new entry's bytes
            if (state_reg == S_DECODE && op_reg == OP_INSERT && in_range && !e_present)
            begin
                used_reg <= used_reg + 35'(size_reg);
            end

            // Drop the victim once its rank sweep is done
            if (state_reg == S_DEC && sweep_done && drop_reg)
            begin
                present_reg[vic_idx_reg] <= 1'b0;
                used_reg                 <= used_reg - 35'(vic_size_reg);
                count_reg                <= count_reg - 1'b1;
            end

            // Mark the inserted entry present
            if (state_reg == S_INSFIN)
            begin
                present_reg[e_idx] <= 1'b1;
                count_reg          <= count_reg + 1'b1;
            end

            // Start or advance a sweep
            if (state_next != state_reg && (state_next == S_SCAN || state_next == S_DEC))
            begin
                ptr_reg  <= '0;
                pend_reg <= 1'b0;
                if (state_next == S_SCAN)
                begin
                    best_v_reg <= 1'b0;
                end
            end
            else if (state_reg == S_SCAN || state_reg == S_DEC)
            begin
                if (ptr_reg != CW'(ENTRIES))
                begin
                    ptr_reg  <= ptr_reg + 1'b1;
                    pend_reg <= 1'b1;
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
                if (state_reg == S_SCAN && scan_hit)
                begin
                    best_v_reg <= 1'b1;
                end
            end

            // Hold or release the result word
            if (emit_ev || emit_fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg    <= op;
            entry_reg <= entry;
            size_reg  <= size_bytes;
        end

        if (state_reg == S_SCAN || state_reg == S_DEC)
        begin
            paddr_reg <= ptr_reg[IW-1:0];
        end

        // Capture the named entry and settle the status word
        if (state_reg == S_DECODE)
        begin
            rec_reg <= rdata;
            if (op_reg == OP_LOCK && rdata.locks != '1)
            begin
                rec_reg.locks <= rdata.locks + 1'b1;
            end
            vic_idx_reg  <= e_idx;
            vic_rank_reg <= rdata.rank;
            vic_size_reg <= rdata.size;
            drop_reg     <= (op_reg == OP_REMOVE);
            df_reg       <= (op_reg == OP_CLEAN) && e_present && rdata.modified;
            if (op_reg > OP_CLEAN || op_reg == OP_FLUSH || op_reg == OP_TRIM)
            begin
                st_reg <= ST_OK;
            end
            else if (!e_present && op_reg != OP_INSERT)
            begin
                st_reg <= ST_ABSENT;
            end
            else if (op_reg == OP_INSERT)
            begin
                st_reg <= !in_range ? ST_ABSENT : (e_present ? ST_PRESENT : ST_OK);
            end
            else if (op_reg == OP_UNLOCK && rdata.locks == '0)
            begin
                st_reg <= ST_UNDERFLOW;
            end
            else
            begin
                st_reg <= ST_OK;
            end
        end

        // Track the oldest unlocked entry
        if (state_reg == S_SCAN)
        begin
            if (scan_hit)
            begin
                vic_idx_reg  <= paddr_reg;
                vic_rank_reg <= rdata.rank;
                vic_size_reg <= rdata.size;
                vic_mod_reg  <= rdata.modified;
            end
            if (sweep_done)
            begin
                drop_reg <= 1'b1;
                // An insert that runs out of victims still ends ok
                if (!best_v_reg && op_reg != OP_INSERT)
                begin
                    st_reg <= ST_NOFLUSH;
                end
            end
        end

        // Load the result word
        if (emit_ev)
        begin
            ev_valid_reg <= 1'b1;
            ev_entry_reg <= 4'(vic_idx_reg);
            ev_dirty_reg <= vic_mod_reg;
            status_reg   <= ST_OK;
            used_out_reg <= used_reg;
            last_reg     <= 1'b0;
        end
        else if (emit_fin)
        begin
            ev_valid_reg <= 1'b0;
            ev_entry_reg <= entry_reg;
            ev_dirty_reg <= df_reg;
            status_reg   <= st_reg;
            used_out_reg <= used_reg;
            last_reg     <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_entry = ev_entry_reg;
    assign evicted_dirty = ev_dirty_reg;
    assign status        = status_reg;
    assign used_bytes    = used_out_reg;
    assign last          = last_reg;

    // Present count tracks the present bits
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CW'($countones(present_reg)))
        else $error("present count out of step with present bits");

    // Eviction words always carry ok status and are never last
    a_evict_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && evicted_valid) |-> (status == ST_OK && !last))
        else $error("eviction word with bad status or last");

    // A victim is only dropped after a scan found one
    a_victim_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && sweep_done && state_next == S_DEC) |-> best_v_reg)
        else $error("rank sweep started without a victim");

    // Memory writes in the sweep only touch present entries
    a_sweep_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEC && mem_we) |-> present_reg[mem_waddr])
        else $error("rank sweep wrote an absent entry");

endmodule

`default_nettype wire

// File: sim/plbc_checker.sv
// Checker for the cache controller: watches the channels, predicts every result word and compares.
`timescale 1ns / 1ps

module plbc_checker
    import plbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [30:0] cfg_wdata,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [3:0]  op,
    input  wire logic [3:0]  entry,
    input  wire logic [30:0] size_bytes,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic        evicted_valid,
    input  wire logic [3:0]  evicted_entry,
    input  wire logic        evicted_dirty,
    input  wire logic [2:0]  status,
    input  wire logic [34:0] used_bytes,
    input  wire logic        last,
    output int               errors,
    output int               pending,
    output int               n_items,
    output int               n_words,
    output int               n_evictions
);

    localparam int NENT    = 16;
    localparam int LOCKMAX = (1 << DEF_LOCK_BITS) - 1;

    typedef struct packed {
        logic        ev;
        logic [3:0]  ent;
        logic        dirty;
        logic [2:0]  st;
        logic [34:0] used;
        logic        fin;
    } cache_word_t;

    cache_word_t expected_words[$];

    // Shadow copy of the cache bookkeeping
    bit          held      [NENT];
    logic [30:0] held_size [NENT];
    int          pin_count [NENT];
    bit          modified  [NENT];
    int          age_rank  [NENT];
    logic [34:0] total_bytes;
    logic [30:0] budget;

    function automatic int count_held();
        int n;
        n = 0;
        for (int i = 0; i < NENT; i++)
            n += held[i];
        return n;
    endfunction

    // Oldest held entry with no pins, -1 if none
    function automatic int pick_victim();
        int best;
        best = -1;
        for (int i = 0; i < NENT; i++)
            if (held[i] && pin_count[i] == 0 && (best < 0 || age_rank[i] < age_rank[best]))
                best = i;
        return best;
    endfunction

    task automatic push_word(bit ev, int ent, bit dirty, logic [2:0] st, bit fin);
        cache_word_t w;
        w.ev    = ev;
        w.ent   = ent[3:0];
        w.dirty = dirty;
        w.st    = st;
        w.used  = total_bytes;
        w.fin   = fin;
        expected_words.push_back(w);
    endtask

    task automatic drop_held(int i);
        for (int j = 0; j < NENT; j++)
            if (held[j] && age_rank[j] > age_rank[i])
                age_rank[j]--;
        held[i]     = 0;
        total_bytes = total_bytes - {4'd0, held_size[i]};
    endtask

    task automatic promote(int i);
        for (int j = 0; j < NENT; j++)
            if (held[j] && j != i && age_rank[j] > age_rank[i])
                age_rank[j]--;
        age_rank[i] = count_held() - 1;
    endtask

    task automatic evict_to_budget();
        int v;
        bit d;
        while (total_bytes > {4'd0, budget})
        begin
            v = pick_victim();
            if (v < 0)
                break;
            d = modified[v];
            drop_held(v);
            n_evictions++;
            push_word(1, v, d, ST_OK, 0);
        end
    endtask

    // Work out every result word that one accepted input word causes
    task automatic predict_op(logic [3:0] code, logic [3:0] idx, logic [30:0] sz);
        int         e;
        int         v;
        bit         d;
        logic [2:0] st;
        e  = idx;
        st = ST_OK;
        d  = 0;
        case (code)
            OP_FLUSH:
            begin
                v = pick_victim();
                if (v < 0)
                    push_word(0, e, 0, ST_NOFLUSH, 1);
                else
                begin
                    d = modified[v];
                    drop_held(v);
                    n_evictions++;
                    push_word(1, v, d, ST_OK, 0);
                    push_word(0, e, 0, ST_OK, 1);
                end
            end
            OP_TRIM:
            begin
                evict_to_budget();
                push_word(0, e, 0, (total_bytes > {4'd0, budget}) ? ST_NOFLUSH : ST_OK, 1);
            end
            OP_INSERT:
            begin
                if (held[e])
                    push_word(0, e, 0, ST_PRESENT, 1);
                else
                begin
                    held_size[e] = sz;
                    pin_count[e] = 0;
                    modified[e]  = 0;
                    total_bytes  = total_bytes + {4'd0, sz};
                    evict_to_budget();
                    age_rank[e] = count_held();
                    held[e]     = 1;
                    push_word(0, e, 0, ST_OK, 1);
                end
            end
            OP_TOUCH, OP_LOCK, OP_UNLOCK, OP_REMOVE, OP_DIRTY, OP_CLEAN:
            begin
                if (!held[e])
                    push_word(0, e, 0, ST_ABSENT, 1);
                else
                begin
                    case (code)
                        OP_TOUCH:
                            promote(e);
                        OP_LOCK:
                        begin
                            if (pin_count[e] < LOCKMAX)
                                pin_count[e]++;
                            promote(e);
                        end
                        OP_UNLOCK:
                        begin
                            if (pin_count[e] == 0)
                                st = ST_UNDERFLOW;
                            else
                                pin_count[e]--;
                        end
                        OP_REMOVE:
                        begin
                            drop_held(e);
                            pin_count[e] = 0;
                            modified[e]  = 0;
                        end
                        OP_DIRTY:
                            modified[e] = 1;
                        default:
                        begin
                            d           = modified[e];
                            modified[e] = 0;
                        end
                    endcase
                    push_word(0, e, d, st, 1);
                end
            end
            // reserved codes answer ok and change nothing
            default:
                push_word(0, e, 0, ST_OK, 1);
        endcase
    endtask

    // Follow the channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        cache_word_t got;
        cache_word_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NENT; i++)
            begin
                held[i]      = 0;
                held_size[i] = '0;
                pin_count[i] = 0;
                modified[i]  = 0;
                age_rank[i]  = 0;
            end
            total_bytes = '0;
            budget      = DEFAULT_LIMIT;
            expected_words.delete();
            errors      = 0;
            pending     = 0;
            n_items     = 0;
            n_words     = 0;
            n_evictions = 0;
        end
        else
        begin
            if (cfg_we)
                budget = cfg_wdata;
            if (in_valid && in_ready)
            begin
                n_items++;
                predict_op(op, entry, size_bytes);
            end
            if (out_valid && out_ready)
            begin
                n_words++;
                got = {evicted_valid, evicted_entry, evicted_dirty, status, used_bytes, last};
                if (expected_words.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word ev=%0b ent=%0d dirty=%0b st=%0d used=%0d last=%0b",
                             $time, got.ev, got.ent, got.dirty, got.st, got.used, got.fin);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: mismatch expected ev=%0b ent=%0d dirty=%0b st=%0d used=%0d last=%0b",
                                 $time, want.ev, want.ent, want.dirty, want.st, want.used, want.fin);
                        $display("%0t:          actual   ev=%0b ent=%0d dirty=%0b st=%0d used=%0d last=%0b",
                                 $time, got.ev, got.ent, got.dirty, got.st, got.used, got.fin);
                    end
                end
            end
            pending = expected_words.size();
        end
    end

endmodule

// File: sim/tb.sv
// Testbench top: clock, reset, stimulus, receiver stalls and the verdict for the cache controller.
`timescale 1ns / 1ps

module tb;
    import plbc_pkg::*;

    localparam logic [3:0] OP_RSVD_LO = 4'd9;
    localparam logic [3:0] OP_RSVD_HI = 4'd15;
    localparam int         CYCLE_CAP  = 10000000;
    localparam int         HOLD_OFF   = 3000;
    localparam int         RANDOM_OPS = 188;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [30:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  op;
    logic [3:0]  entry;
    logic [30:0] size_bytes;
    logic        out_valid;
    logic        out_ready;
    logic        evicted_valid;
    logic [3:0]  evicted_entry;
    logic        evicted_dirty;
    logic [2:0]  status;
    logic [34:0] used_bytes;
    logic        last;

    int errors;
    int pending;
    int n_items;
    int n_words;
    int n_evictions;
    int cycles;
    bit hold_req;

    pinned_lru_byte_budget_cache_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .entry         (entry),
        .size_bytes    (size_bytes),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .evicted_valid (evicted_valid),
        .evicted_entry (evicted_entry),
        .evicted_dirty (evicted_dirty),
        .status        (status),
        .used_bytes    (used_bytes),
        .last          (last)
    );

    plbc_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .entry         (entry),
        .size_bytes    (size_bytes),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .evicted_valid (evicted_valid),
        .evicted_entry (evicted_entry),
        .evicted_dirty (evicted_dirty),
        .status        (status),
        .used_bytes    (used_bytes),
        .last          (last),
        .errors        (errors),
        .pending       (pending),
        .n_items       (n_items),
        .n_words       (n_words),
        .n_evictions   (n_evictions)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_CAP)
            begin
                $display("timeout after %0d cycles, %0d words still due", cycles, pending);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, plus one long hold-off when asked
    initial
    begin
        int n;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 0;
                repeat (HOLD_OFF) @(posedge clk);
                hold_req = 0;
            end
            n = gap_len();
            if (n > 0)
            begin
                out_ready <= 0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    // Offer one input word and hold it until accepted
    task automatic send_op(logic [3:0] code, logic [3:0] idx, logic [30:0] sz);
        int n;
        n = gap_len();
        if (n > 0)
        begin
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
        in_valid   <= 1;
        op         <= code;
        entry      <= idx;
        size_bytes <= sz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Let the block drain, then change the budget
    task automatic set_budget(logic [30:0] value);
        in_valid <= 0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        cfg_we    <= 1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 0;
    endtask

    task automatic random_phase(int count, logic [30:0] size_cap, bit full_sizes);
        int          r;
        logic [3:0]  code;
        logic [30:0] sz;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 34)
                code = OP_INSERT;
            else if (r < 44)
                code = OP_TOUCH;
            else if (r < 54)
                code = OP_LOCK;
            else if (r < 66)
                code = OP_UNLOCK;
            else if (r < 74)
                code = OP_REMOVE;
            else if (r < 80)
                code = OP_FLUSH;
            else if (r < 85)
                code = OP_TRIM;
            else if (r < 91)
                code = OP_DIRTY;
            else if (r < 97)
                code = OP_CLEAN;
            else
                code = 4'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
            if (full_sizes)
                sz = 31'($urandom());
            else
                sz = 31'($urandom_range(0, size_cap));
            send_op(code, 4'($urandom_range(0, 15)), sz);
        end
    endtask

    initial
    begin
        rst_n      = 0;
        cfg_we     = 0;
        cfg_wdata  = '0;
        in_valid   = 0;
        op         = OP_INSERT;
        entry      = '0;
        size_bytes = '0;
        hold_req   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty cache, duplicates, pinning, dirty tracking, reserved codes
        set_budget(31'd100);
        send_op(OP_FLUSH, 4'd0, '0);
        send_op(OP_TRIM, 4'd0, '0);
        send_op(OP_TOUCH, 4'd3, '0);
        send_op(OP_INSERT, 4'd0, '0);
        send_op(OP_INSERT, 4'd0, 31'd5);
        send_op(OP_INSERT, 4'd1, 31'd60);
        send_op(OP_LOCK, 4'd1, '0);
        send_op(OP_INSERT, 4'd2, 31'd50);
        send_op(OP_DIRTY, 4'd2, '0);
        send_op(OP_TRIM, 4'd9, '0);
        send_op(OP_UNLOCK, 4'd1, '0);
        send_op(OP_UNLOCK, 4'd1, '0);
        send_op(OP_LOCK, 4'd1, '0);
        send_op(OP_REMOVE, 4'd1, '0);
        send_op(OP_INSERT, 4'd3, 31'h7fff_ffff);
        send_op(OP_INSERT, 4'd4, '0);
        send_op(OP_DIRTY, 4'd4, '0);
        send_op(OP_CLEAN, 4'd4, '0);
        send_op(OP_CLEAN, 4'd4, '0);
        send_op(OP_FLUSH, 4'd15, '0);
        send_op(OP_RSVD_LO, 4'd7, 31'h7fff_ffff);
        send_op(OP_RSVD_HI, 4'd15, '0);
        send_op(OP_REMOVE, 4'd3, '0);

        // Pin count runs into its ceiling
        send_op(OP_INSERT, 4'd5, 31'd1);
        for (int k = 0; k < (1 << DEF_LOCK_BITS) + 2; k++)
            send_op(OP_LOCK, 4'd5, '0);
        send_op(OP_UNLOCK, 4'd5, '0);
        send_op(OP_REMOVE, 4'd5, '0);

        // Random: tight, zero, full and random budgets; the receiver holds off part way through
        set_budget(31'd1000);
        hold_req = 1;
        random_phase(RANDOM_OPS / 4, 31'd400, 0);
        set_budget('0);
        random_phase(RANDOM_OPS / 4, 31'd20, 0);
        set_budget(31'h7fff_ffff);
        random_phase(RANDOM_OPS / 4, '0, 1);
        set_budget(31'($urandom_range(1000, 100000)));
        random_phase(RANDOM_OPS / 4, 31'd30000, 0);

        // Drain and settle
        in_valid <= 0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d input words and %0d result words, %0d of them evictions",
                 n_items, n_words, n_evictions);
        $display("budgets of 0, 100, 1000, the 31-bit maximum and one random value");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
